### rtl/extended_memory_handle_allocator_unit_assert.svh
// Assertion macros shared by the allocator RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef EXTENDED_MEMORY_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH
`define EXTENDED_MEMORY_HANDLE_ALLOCATOR_UNIT_ASSERT_SVH

`define EMHA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

`define EMHA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### rtl/emha_pkg.sv
// Types and constants of the extended memory handle allocator.
// No dependencies.
package emha_pkg;

	typedef enum logic [2:0] {
		OP_ALLOC  = 3'd0,
		OP_FREE   = 3'd1,
		OP_LOCK   = 3'd2,
		OP_UNLOCK = 3'd3,
		OP_RESIZE = 3'd4,
		OP_QUERY  = 3'd5,
		OP_MOVE   = 3'd6
	} op_t;

	typedef enum logic [3:0] {
		ST_OK             = 4'd0,
		ST_NO_SPACE       = 4'd1,
		ST_NO_HANDLES     = 4'd2,
		ST_BAD_HANDLE     = 4'd3,
		ST_BAD_SRC_HANDLE = 4'd4,
		ST_BAD_SRC_OFFSET = 4'd5,
		ST_BAD_DST_HANDLE = 4'd6,
		ST_BAD_DST_OFFSET = 4'd7,
		ST_BAD_LENGTH     = 4'd8,
		ST_NOT_LOCKED     = 4'd9,
		ST_LOCKED         = 4'd10
	} status_t;

	typedef enum logic [1:0] {
		SIDE_OK   = 2'd0,
		SIDE_HDL  = 2'd1,
		SIDE_OFS  = 2'd2,
		SIDE_LEN  = 2'd3
	} side_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_READ = 2'd1,
		S_EXEC = 2'd2
	} state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

	localparam logic [15:0] TOTAL_KB_RESET = 16'd15360;
	localparam logic [7:0]  LOCK_MAX       = 8'd255;
	localparam logic [26:0] HMA_BASE       = 27'h100000;

endpackage

### rtl/emha_if.sv
// Request and response channel interfaces of the allocator.
// Depends on nothing but plain logic types.
interface emha_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [15:0] handle;
	logic [15:0] size_kb;
	logic [15:0] source_handle;
	logic [31:0] source_offset;
	logic [15:0] dest_handle;
	logic [31:0] dest_offset;
	logic [31:0] move_length;

	modport source (output valid, opcode, handle, size_kb, source_handle, source_offset,
		dest_handle, dest_offset, move_length, input ready);
	modport sink (input valid, opcode, handle, size_kb, source_handle, source_offset,
		dest_handle, dest_offset, move_length, output ready);
endinterface

interface emha_rsp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [5:0]  new_handle;
	logic [26:0] lock_address;
	logic [15:0] free_kb;

	modport source (output valid, status, new_handle, lock_address, free_kb, input ready);
	modport sink (input valid, status, new_handle, lock_address, free_kb, output ready);
endinterface

### rtl/emha_ctrl.sv
// Sequencing state machine of the allocator: capture, table read, execute.
// Depends on emha_pkg.
module emha_ctrl import emha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt   = state_q;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		req_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_READ;
				end
			end
			S_READ: begin
				state_nxt = S_EXEC;
			end
			S_EXEC: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

### rtl/emha_dp.sv
// Datapath of the allocator: handle tables, free-handle search and result register.
// Depends on emha_pkg and on commands from emha_ctrl.
module emha_dp import emha_pkg::*; #(
	parameter int NUM_HANDLES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic [2:0]  opcode,
	input  logic [15:0] handle,
	input  logic [15:0] size_kb,
	input  logic [15:0] source_handle,
	input  logic [31:0] source_offset,
	input  logic [15:0] dest_handle,
	input  logic [31:0] dest_offset,
	input  logic [31:0] move_length,
	output logic [3:0]  status,
	output logic [5:0]  new_handle,
	output logic [26:0] lock_address,
	output logic [15:0] free_kb
);

	localparam int HW = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
	localparam int NG = (NUM_HANDLES + 7) / 8;

	logic [15:0] base_mem [NUM_HANDLES];
	logic [15:0] size_mem [NUM_HANDLES];
	logic [7:0]  lock_mem [NUM_HANDLES];
	logic [NUM_HANDLES-1:0] in_use_q;
	logic [15:0] total_kb_q, used_kb_q;

	logic [2:0]  op_q;
	logic [15:0] hdl_q, sz_q, sh_q, dh_q;
	logic [31:0] so_q, do_q, len_q;

	logic [15:0] base_a_s1, size_a_s1, size_b_s1;
	logic [7:0]  lock_a_s1;
	logic [NG-1:0] grp_any_s1;
	logic [2:0]  grp_idx_s1 [NG];

	logic [NG*8-1:0] avail;
	logic [HW-1:0] rd_a, rd_b;

	logic [3:0]  st_q;
	logic [5:0]  nh_q;
	logic [26:0] addr_q;
	logic [15:0] fkb_q;

	always_comb begin
		avail = '0;
		for (int i = 1; i < NUM_HANDLES; i++) begin
			avail[i] = !in_use_q[i];
		end
	end

	assign rd_a = (op_t'(opcode) == OP_MOVE) ? source_handle[HW-1:0] : handle[HW-1:0];
	assign rd_b = dest_handle[HW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= opcode;
			hdl_q     <= handle;
			sz_q      <= size_kb;
			sh_q      <= source_handle;
			so_q      <= source_offset;
			dh_q      <= dest_handle;
			do_q      <= dest_offset;
			len_q     <= move_length;
			base_a_s1 <= base_mem[rd_a];
			size_a_s1 <= size_mem[rd_a];
			lock_a_s1 <= lock_mem[rd_a];
			size_b_s1 <= size_mem[rd_b];
			for (int g = 0; g < NG; g++) begin
				grp_any_s1[g] <= |avail[g*8 +: 8];
				grp_idx_s1[g] <= 3'd0;
				for (int b = 7; b >= 0; b--) begin
					if (avail[g*8 + b]) begin
						grp_idx_s1[g] <= 3'(b);
					end
				end
			end
		end
	end

	logic          ff_found;
	logic [HW-1:0] ff_idx;

	always_comb begin
		ff_found = 1'b0;
		ff_idx   = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				ff_found = 1'b1;
				ff_idx   = HW'(g * 8 + int'(grp_idx_s1[g]));
			end
		end
	end

	logic        h_ok, sh_ok, dh_ok, topmost;
	logic [16:0] free_sp, top_diff, grow_need;
	logic [15:0] free16;
	side_t       side_s, side_d;

	assign h_ok  = (hdl_q != '0) && (hdl_q < 16'(NUM_HANDLES)) && in_use_q[hdl_q[HW-1:0]];
	assign sh_ok = (sh_q < 16'(NUM_HANDLES)) && in_use_q[sh_q[HW-1:0]];
	assign dh_ok = (dh_q < 16'(NUM_HANDLES)) && in_use_q[dh_q[HW-1:0]];

	assign free_sp   = {1'b0, total_kb_q} - {1'b0, used_kb_q};
	assign free16    = free_sp[16] ? 16'd0 : free_sp[15:0];
	assign top_diff  = {1'b0, used_kb_q} - {1'b0, size_a_s1};
	assign topmost   = (top_diff == {1'b0, base_a_s1});
	assign grow_need = ({1'b0, sz_q} - {1'b0, size_a_s1}) + {1'b0, used_kb_q};

	function automatic side_t check_side(input logic nz, input logic ok,
		input logic [15:0] sz, input logic [31:0] off, input logic [31:0] len);
		logic [31:0] bytes;
		bytes = {6'd0, sz, 10'd0};
		if (!nz) begin
			return SIDE_OK;
		end else if (!ok) begin
			return SIDE_HDL;
		end else if (off >= bytes) begin
			return SIDE_OFS;
		end else if (len > bytes - off) begin
			return SIDE_LEN;
		end
		return SIDE_OK;
	endfunction

	assign side_s = check_side(sh_q != '0, sh_ok, size_a_s1, so_q, len_q);
	assign side_d = check_side(dh_q != '0, dh_ok, size_b_s1, do_q, len_q);

	status_t       st_nxt;
	logic [HW-1:0] wr_idx;
	logic          we_base, we_size, we_lock, set_use, clr_use, we_used;
	logic [15:0]   used_nxt, size_wr;
	logic [7:0]    lock_wr;
	logic [26:0]   addr_nxt;
	logic [15:0]   fkb_nxt;
	logic          nh_en;
	logic [HW+5:0] nh_wide;

	always_comb begin
		st_nxt   = ST_OK;
		wr_idx   = hdl_q[HW-1:0];
		we_base  = 1'b0;
		we_size  = 1'b0;
		we_lock  = 1'b0;
		set_use  = 1'b0;
		clr_use  = 1'b0;
		we_used  = 1'b0;
		used_nxt = used_kb_q;
		size_wr  = sz_q;
		lock_wr  = 8'd0;
		addr_nxt = '0;
		fkb_nxt  = '0;
		nh_en    = 1'b0;
		case (op_q)
			OP_ALLOC: begin
				wr_idx = ff_idx;
				if (!ff_found) begin
					st_nxt = ST_NO_HANDLES;
				end else if ({1'b0, free16} < {1'b0, sz_q}) begin
					st_nxt = ST_NO_SPACE;
				end else begin
					we_base  = 1'b1;
					we_size  = 1'b1;
					we_lock  = 1'b1;
					set_use  = 1'b1;
					we_used  = 1'b1;
					used_nxt = used_kb_q + sz_q;
					nh_en    = 1'b1;
				end
			end
			OP_FREE: begin
				if (!h_ok) begin
					st_nxt = ST_BAD_HANDLE;
				end else begin
					clr_use = 1'b1;
					if (topmost) begin
						we_used  = 1'b1;
						used_nxt = top_diff[15:0];
					end
				end
			end
			OP_LOCK: begin
				if (!h_ok) begin
					st_nxt = ST_BAD_HANDLE;
				end else begin
					we_lock  = 1'b1;
					lock_wr  = (lock_a_s1 < LOCK_MAX) ? lock_a_s1 + 8'd1 : lock_a_s1;
					addr_nxt = {1'b0, base_a_s1, 10'd0} + HMA_BASE;
				end
			end
			OP_UNLOCK: begin
				if (!h_ok) begin
					st_nxt = ST_BAD_HANDLE;
				end else if (lock_a_s1 != 8'd0) begin
					we_lock = 1'b1;
					lock_wr = lock_a_s1 - 8'd1;
				end else begin
					st_nxt = ST_NOT_LOCKED;
				end
			end
			OP_RESIZE: begin
				if (!h_ok) begin
					st_nxt = ST_BAD_HANDLE;
				end else if (lock_a_s1 != 8'd0) begin
					st_nxt = ST_LOCKED;
				end else if (topmost) begin
					if (size_a_s1 >= sz_q) begin
						we_size  = 1'b1;
						we_used  = 1'b1;
						used_nxt = used_kb_q - (size_a_s1 - sz_q);
					end else if (grow_need > {1'b0, total_kb_q}) begin
						st_nxt = ST_NO_SPACE;
					end else begin
						we_size  = 1'b1;
						we_used  = 1'b1;
						used_nxt = grow_need[15:0];
					end
				end else if (size_a_s1 >= sz_q) begin
					we_size = 1'b1;
				end else begin
					st_nxt = ST_NO_SPACE;
				end
			end
			OP_QUERY: begin
				fkb_nxt = free16;
				if (free16 == 16'd0) begin
					st_nxt = ST_NO_SPACE;
				end
			end
			OP_MOVE: begin
				case (side_s)
					SIDE_HDL: st_nxt = ST_BAD_SRC_HANDLE;
					SIDE_OFS: st_nxt = ST_BAD_SRC_OFFSET;
					SIDE_LEN: st_nxt = ST_BAD_LENGTH;
					default: begin
						case (side_d)
							SIDE_HDL: st_nxt = ST_BAD_DST_HANDLE;
							SIDE_OFS: st_nxt = ST_BAD_DST_OFFSET;
							SIDE_LEN: st_nxt = ST_BAD_LENGTH;
							default:  st_nxt = ST_OK;
						endcase
					end
				endcase
			end
			default: begin
				st_nxt = ST_OK;
			end
		endcase
	end

	assign nh_wide = (HW + 6)'(ff_idx);

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (we_base) begin
				base_mem[wr_idx] <= used_kb_q;
			end
			if (we_size) begin
				size_mem[wr_idx] <= size_wr;
			end
			if (we_lock) begin
				lock_mem[wr_idx] <= lock_wr;
			end
			st_q   <= st_nxt;
			nh_q   <= nh_en ? nh_wide[5:0] : 6'd0;
			addr_q <= addr_nxt;
			fkb_q  <= fkb_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q   <= '0;
			used_kb_q  <= '0;
			total_kb_q <= TOTAL_KB_RESET;
		end else begin
			if (cfg_we) begin
				total_kb_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				if (set_use) begin
					in_use_q[wr_idx] <= 1'b1;
				end
				if (clr_use) begin
					in_use_q[wr_idx] <= 1'b0;
				end
				if (we_used) begin
					used_kb_q <= used_nxt;
				end
			end
		end
	end

	assign status       = st_q;
	assign new_handle   = nh_q;
	assign lock_address = addr_q;
	assign free_kb      = fkb_q;

endmodule

### rtl/extended_memory_handle_allocator_unit.sv
// Top level of the extended memory handle allocator.
// Depends on emha_pkg, emha_if, emha_ctrl, emha_dp and the assertion macro header.
//
// Channel  Role   Handshake     Carries
// req      sink   valid/ready   opcode, handles, size, offsets, length
// rsp      source valid/ready   status, new handle, lock address, free KB
// cfg      write  cfg_we        total_kb
//
// Each transaction: capture with table read, S_READ, then execute with result load.
// The table memories read on the capture edge and write on the execute edge, one
// transaction at a time. A stalled response holds the execute step until the result
// register frees up. Reset clears the handle map and used count; no clearing pass.
`include "extended_memory_handle_allocator_unit_assert.svh"

module extended_memory_handle_allocator_unit import emha_pkg::*; #(
	parameter int NUM_HANDLES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	emha_req_if.sink    req,
	emha_rsp_if.source  rsp
);

	cmd_t cmd;

	emha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	emha_dp #(
		.NUM_HANDLES (NUM_HANDLES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.opcode        (req.opcode),
		.handle        (req.handle),
		.size_kb       (req.size_kb),
		.source_handle (req.source_handle),
		.source_offset (req.source_offset),
		.dest_handle   (req.dest_handle),
		.dest_offset   (req.dest_offset),
		.move_length   (req.move_length),
		.status        (rsp.status),
		.new_handle    (rsp.new_handle),
		.lock_address  (rsp.lock_address),
		.free_kb       (rsp.free_kb)
	);

	`EMHA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "accepted while busy")
	`EMHA_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp.valid, "result not presented after execute")
	`EMHA_ASSERT_SAME(a_handle_ok, rsp.valid && rsp.new_handle != 6'd0, rsp.status == ST_OK, "handle granted with error")

endmodule

### verif/tb_extended_memory_handle_allocator_unit.sv
// Self-checking testbench for extended_memory_handle_allocator_unit.
// Depends on emha_pkg, the emha_req_if and emha_rsp_if interfaces and the RTL top level.
// Requests are predicted on acceptance and every response is checked against the oldest one.
module tb_extended_memory_handle_allocator_unit;
	import emha_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          HANDLE_COUNT = 64;
	localparam logic [2:0]  OP_UNKNOWN   = 3'd7;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] handle;
		logic [15:0] size_kb;
		logic [15:0] source_handle;
		logic [31:0] source_offset;
		logic [15:0] dest_handle;
		logic [31:0] dest_offset;
		logic [31:0] move_length;
	} request_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  new_handle;
		logic [26:0] lock_address;
		logic [15:0] free_kb;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	emha_req_if req_ch();
	emha_rsp_if rsp_ch();

	extended_memory_handle_allocator_unit #(.NUM_HANDLES(HANDLE_COUNT)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Shadow state of the allocator.
	logic [15:0] model_total_kb;
	logic        model_in_use [HANDLE_COUNT];
	logic [15:0] model_base_kb [HANDLE_COUNT];
	logic [15:0] model_size_kb [HANDLE_COUNT];
	logic [7:0]  model_locks [HANDLE_COUNT];
	logic [15:0] model_used_kb;

	outcome_t pending_outcomes[$];
	int  error_count = 0;
	bit  quiet = 0;
	int  long_hold = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("extended_memory_handle_allocator_unit verification failed");
		$finish;
	end

	function automatic bit handle_ok(logic [15:0] h);
		return h != 0 && h < HANDLE_COUNT && model_in_use[h[5:0]];
	endfunction

	function automatic int unsigned space_left();
		if (model_used_kb > model_total_kb)
			return 0;
		return model_total_kb - model_used_kb;
	endfunction

	function automatic side_t side_check(logic [15:0] h, logic [31:0] ofs, logic [31:0] len);
		longint unsigned bytes;
		if (h == 0)
			return SIDE_OK;
		if (!handle_ok(h))
			return SIDE_HDL;
		bytes = longint'(model_size_kb[h[5:0]]) * 1024;
		if (ofs >= bytes)
			return SIDE_OFS;
		if (len > bytes - ofs)
			return SIDE_LEN;
		return SIDE_OK;
	endfunction

	function automatic outcome_t allocator_step(request_t r);
		outcome_t o;
		int unsigned i;
		int unsigned cur;
		logic [5:0] h;
		side_t s;
		bit top;
		o = '0;
		o.status = ST_OK;
		h = r.handle[5:0];
		top = handle_ok(r.handle) &&
			(int'(model_used_kb) - int'(model_size_kb[h]) == int'(model_base_kb[h]));
		case (r.opcode)
			OP_ALLOC: begin
				for (i = 1; i < HANDLE_COUNT; i++)
					if (!model_in_use[i])
						break;
				if (i >= HANDLE_COUNT)
					o.status = ST_NO_HANDLES;
				else if (space_left() < r.size_kb)
					o.status = ST_NO_SPACE;
				else begin
					model_in_use[i] = 1;
					model_base_kb[i] = model_used_kb;
					model_size_kb[i] = r.size_kb;
					model_locks[i] = 0;
					model_used_kb = model_used_kb + r.size_kb;
					o.new_handle = i[5:0];
				end
			end
			OP_FREE: begin
				if (!handle_ok(r.handle))
					o.status = ST_BAD_HANDLE;
				else begin
					if (top)
						model_used_kb = model_used_kb - model_size_kb[h];
					model_size_kb[h] = 0;
					model_in_use[h] = 0;
				end
			end
			OP_LOCK: begin
				if (!handle_ok(r.handle))
					o.status = ST_BAD_HANDLE;
				else begin
					if (model_locks[h] < LOCK_MAX)
						model_locks[h]++;
					o.lock_address = {model_base_kb[h], 10'd0} + HMA_BASE;
				end
			end
			OP_UNLOCK: begin
				if (!handle_ok(r.handle))
					o.status = ST_BAD_HANDLE;
				else if (model_locks[h] != 0)
					model_locks[h]--;
				else
					o.status = ST_NOT_LOCKED;
			end
			OP_RESIZE: begin
				cur = model_size_kb[h];
				if (!handle_ok(r.handle))
					o.status = ST_BAD_HANDLE;
				else if (model_locks[h] != 0)
					o.status = ST_LOCKED;
				else if (top) begin
					if (cur >= r.size_kb) begin
						model_used_kb = 16'(model_used_kb - (cur - r.size_kb));
						model_size_kb[h] = r.size_kb;
					end else if ((r.size_kb - cur) + model_used_kb > model_total_kb)
						o.status = ST_NO_SPACE;
					else begin
						model_used_kb = 16'(model_used_kb + (r.size_kb - cur));
						model_size_kb[h] = r.size_kb;
					end
				end else if (cur >= r.size_kb)
					model_size_kb[h] = r.size_kb;
				else
					o.status = ST_NO_SPACE;
			end
			OP_QUERY: begin
				o.free_kb = 16'(space_left());
				if (o.free_kb == 0)
					o.status = ST_NO_SPACE;
			end
			OP_MOVE: begin
				s = side_check(r.source_handle, r.source_offset, r.move_length);
				if (s == SIDE_HDL)
					o.status = ST_BAD_SRC_HANDLE;
				else if (s == SIDE_OFS)
					o.status = ST_BAD_SRC_OFFSET;
				else if (s == SIDE_LEN)
					o.status = ST_BAD_LENGTH;
				else begin
					s = side_check(r.dest_handle, r.dest_offset, r.move_length);
					if (s == SIDE_HDL)
						o.status = ST_BAD_DST_HANDLE;
					else if (s == SIDE_OFS)
						o.status = ST_BAD_DST_OFFSET;
					else if (s == SIDE_LEN)
						o.status = ST_BAD_LENGTH;
				end
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	// Acceptance monitor and response checker.
	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = {status_t'(rsp_ch.status), rsp_ch.new_handle, rsp_ch.lock_address,
				rsp_ch.free_kb};
			if (pending_outcomes.size() == 0) begin
				$display("%0t unexpected response %p", $time, got);
				error_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (got.status !== want.status) begin
					$display("%0t status expected %0d actual %0d", $time, want.status, got.status);
					error_count++;
				end
				if (got.new_handle !== want.new_handle) begin
					$display("%0t new_handle expected %0d actual %0d", $time,
						want.new_handle, got.new_handle);
					error_count++;
				end
				if (got.lock_address !== want.lock_address) begin
					$display("%0t lock_address expected %h actual %h", $time,
						want.lock_address, got.lock_address);
					error_count++;
				end
				if (got.free_kb !== want.free_kb) begin
					$display("%0t free_kb expected %0d actual %0d", $time,
						want.free_kb, got.free_kb);
					error_count++;
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready)
			pending_outcomes.push_back(allocator_step({req_ch.opcode, req_ch.handle,
				req_ch.size_kb, req_ch.source_handle, req_ch.source_offset,
				req_ch.dest_handle, req_ch.dest_offset, req_ch.move_length}));
	end

	// Response back-pressure.
	initial begin
		int burst;
		burst = 0;
		rsp_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				rsp_ch.ready = 0;
				long_hold--;
			end else if (burst > 0) begin
				rsp_ch.ready = 0;
				burst--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(0, 14);
				rsp_ch.ready = 0;
			end else
				rsp_ch.ready = 1;
		end
	end

	task automatic send_request(request_t r);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 15);
			req_ch.valid = 0;
			repeat (gap) @(negedge clk);
		end
		{req_ch.opcode, req_ch.handle, req_ch.size_kb, req_ch.source_handle,
			req_ch.source_offset, req_ch.dest_handle, req_ch.dest_offset,
			req_ch.move_length} = r;
		req_ch.valid = 1;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_ch.valid = 0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_total(logic [15:0] kb);
		wait_idle();
		@(negedge clk);
		cfg_we = 1;
		cfg_wdata = kb;
		@(posedge clk);
		model_total_kb = kb;
		@(negedge clk);
		cfg_we = 0;
	endtask

	function automatic request_t make_request(logic [2:0] op, logic [15:0] h, logic [15:0] sz);
		request_t r;
		r = '0;
		r.opcode = op;
		r.handle = h;
		r.size_kb = sz;
		return r;
	endfunction

	function automatic request_t make_move(logic [15:0] sh, logic [31:0] so, logic [15:0] dh,
		logic [31:0] dof, logic [31:0] len);
		request_t r;
		r = make_request(OP_MOVE, 0, 0);
		r.source_handle = sh;
		r.source_offset = so;
		r.dest_handle = dh;
		r.dest_offset = dof;
		r.move_length = len;
		return r;
	endfunction

	function automatic logic [15:0] pick_handle();
		int live[$];
		for (int i = 1; i < HANDLE_COUNT; i++)
			if (model_in_use[i])
				live.push_back(i);
		if (live.size() != 0 && $urandom_range(0, 9) < 8)
			return 16'(live[$urandom_range(0, live.size() - 1)]);
		if ($urandom_range(0, 1))
			return 16'($urandom_range(0, 70));
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic logic [31:0] pick_offset(logic [15:0] h);
		longint unsigned bytes;
		bytes = (h < HANDLE_COUNT && model_in_use[h[5:0]]) ?
			longint'(model_size_kb[h[5:0]]) * 1024 : 0;
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'(bytes);
			2: return (bytes == 0) ? 32'd0 : 32'(bytes - 1);
			default: return $urandom_range(0, int'(bytes) + 2);
		endcase
	endfunction

	function automatic request_t random_fill();
		request_t r;
		r.opcode = 3'($urandom_range(0, 7));
		r.handle = 16'($urandom);
		r.size_kb = 16'($urandom);
		r.source_handle = 16'($urandom);
		r.source_offset = $urandom;
		r.dest_handle = 16'($urandom);
		r.dest_offset = $urandom;
		r.move_length = $urandom;
		return r;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int pct;
		logic [15:0] sz;
		pct = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: sz = 16'($urandom_range(0, 65535));
			1: sz = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
			default: sz = 16'($urandom_range(0, 200));
		endcase
		if (pct < 26)
			r = make_request(OP_ALLOC, 16'($urandom_range(0, 65535)), sz);
		else if (pct < 45)
			r = make_request(OP_FREE, pick_handle(), 16'($urandom_range(0, 65535)));
		else if (pct < 57)
			r = make_request(OP_LOCK, pick_handle(), 0);
		else if (pct < 68)
			r = make_request(OP_UNLOCK, pick_handle(), 0);
		else if (pct < 81)
			r = make_request(OP_RESIZE, pick_handle(), sz);
		else if (pct < 85)
			r = make_request(OP_QUERY, 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
		else if (pct < 99) begin
			r = make_move($urandom_range(0, 5) == 0 ? 16'h0 : pick_handle(), 0,
				$urandom_range(0, 5) == 0 ? 16'h0 : pick_handle(), 0, 0);
			r.source_offset = pick_offset(r.source_handle);
			r.dest_offset = pick_offset(r.dest_handle);
			r.move_length = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 70000);
		end else begin
			r = random_fill();
			r.opcode = OP_UNKNOWN;
		end
		return r;
	endfunction

	task automatic test_allocate_and_free();
		send_request(make_request(OP_ALLOC, 0, 0));
		send_request(make_request(OP_ALLOC, 0, 100));
		send_request(make_request(OP_ALLOC, 0, 16'hFFFF));
		send_request(make_request(OP_ALLOC, 0, 50));
		send_request(make_request(OP_FREE, 2, 0));
		send_request(make_request(OP_FREE, 2, 0));
		send_request(make_request(OP_FREE, 0, 0));
		send_request(make_request(OP_FREE, 16'hFFFF, 0));
		send_request(make_request(OP_QUERY, 0, 0));
		send_request(make_request(OP_FREE, 3, 0));
		send_request(make_request(OP_QUERY, 0, 0));
		send_request(make_request(OP_UNKNOWN, 16'hFFFF, 16'hFFFF));
	endtask

	task automatic test_lock_and_resize();
		send_request(make_request(OP_ALLOC, 0, 20));
		send_request(make_request(OP_UNLOCK, 2, 0));
		send_request(make_request(OP_LOCK, 2, 0));
		send_request(make_request(OP_RESIZE, 2, 10));
		send_request(make_request(OP_UNLOCK, 2, 0));
		send_request(make_request(OP_RESIZE, 2, 40));
		send_request(make_request(OP_RESIZE, 2, 5));
		send_request(make_request(OP_RESIZE, 1, 4));
		send_request(make_request(OP_RESIZE, 2, 16'hFFFF));
		repeat (260) send_request(make_request(OP_LOCK, 2, 0));
		repeat (256) send_request(make_request(OP_UNLOCK, 2, 0));
	endtask

	task automatic test_move_check();
		send_request(make_move(0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF, 32'hFFFFFFFF));
		send_request(make_move(9, 0, 9, 0, 0));
		send_request(make_move(2, 5 * 1024, 0, 0, 0));
		send_request(make_move(2, 100, 0, 0, 5 * 1024));
		send_request(make_move(2, 1, 0, 0, 5 * 1024 - 1));
		send_request(make_move(2, 0, 9, 0, 3));
		send_request(make_move(0, 0, 2, 5 * 1024, 3));
		send_request(make_move(2, 0, 2, 4, 5 * 1024 - 3));
	endtask

	task automatic test_space_limits();
		write_total(16'd10);
		send_request(make_request(OP_QUERY, 0, 0));
		send_request(make_request(OP_ALLOC, 0, 0));
		send_request(make_request(OP_RESIZE, 2, 6));
		write_total(16'd0);
		send_request(make_request(OP_QUERY, 0, 0));
		write_total(16'hFFFF);
		send_request(make_request(OP_QUERY, 0, 0));
		repeat (64) send_request(make_request(OP_ALLOC, 0, 0));
		wait_idle();
		for (int i = 1; i < HANDLE_COUNT; i++)
			send_request(make_request(OP_FREE, 16'(i), 0));
	endtask

	task automatic test_random_traffic();
		logic [15:0] totals[5] = '{16'd15360, 16'd600, 16'hFFFF, 16'd0, 16'd2000};
		for (int p = 0; p < 5; p++) begin
			write_total(p == 3 ? 16'($urandom) : totals[p]);
			quiet = (p == 4);
			if (p == 1)
				long_hold = 400;
			for (int n = 0; n < 250; n++)
				send_request(random_request());
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		req_ch.valid = 0;
		{req_ch.opcode, req_ch.handle, req_ch.size_kb, req_ch.source_handle,
			req_ch.source_offset, req_ch.dest_handle, req_ch.dest_offset,
			req_ch.move_length} = '0;
		model_total_kb = TOTAL_KB_RESET;
		model_used_kb = 0;
		for (int i = 0; i < HANDLE_COUNT; i++) begin
			model_in_use[i] = 0;
			model_base_kb[i] = 0;
			model_size_kb[i] = 0;
			model_locks[i] = 0;
		end
		repeat (11) @(negedge clk);
		arst_n = 1;
		test_allocate_and_free();
		test_lock_and_resize();
		test_move_check();
		test_space_limits();
		test_random_traffic();
		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("extended_memory_handle_allocator_unit verification clean");
		else
			$display("extended_memory_handle_allocator_unit verification failed");
		$finish;
	end
endmodule
